>>> design/trdiv_pkg.sv
`default_nettype none

package trdiv_pkg;

  // default operand width of the factorizer
  localparam int VALUE_BITS_DEF = 32;

  // fixed field widths of the stream items
  localparam int IN_DATA_W  = 32;
  localparam int PRIME_W    = 32;
  localparam int EXP_W      = 5;
  localparam int OUT_DATA_W = 40;
  localparam int OUT_PAD_W  = OUT_DATA_W - PRIME_W - EXP_W;

  // sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ONE,
    ST_TRY,
    ST_WAIT,
    ST_NEXT,
    ST_FINISH
  } state_t;

endpackage

`default_nettype wire

>>> design/trdiv_divider.sv
`default_nettype none

module trdiv_divider #(
  parameter int DW = trdiv_pkg::VALUE_BITS_DEF
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          start,
  input  wire logic [DW-1:0] dividend,
  input  wire logic [DW-1:0] divisor,
  output logic               done,
  output logic [DW-1:0]      quotient,
  output logic [DW-1:0]      remainder
);

  localparam int CW = $clog2(DW + 1);

  logic [CW-1:0] cnt;
  logic [DW-1:0] quo;
  logic [DW-1:0] acc;
  logic [DW-1:0] dvs;
  logic [DW:0]   trial;
  logic [DW:0]   diff;
  logic          fits;
  logic [DW-1:0] acc_next;

  // one restoring step per cycle
  always_comb begin
    trial    = {acc, quo[DW-1]};
    diff     = trial - {1'b0, dvs};
    fits     = (trial >= {1'b0, dvs});
    acc_next = fits ? diff[DW-1:0] : trial[DW-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        cnt <= CW'(DW);
      end else if (cnt != '0) begin
        cnt  <= cnt - CW'(1);
        done <= (cnt == CW'(1));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo <= dividend;
      acc <= '0;
      dvs <= divisor;
    end else if (cnt != '0) begin
      acc <= acc_next;
      quo <= {quo[DW-2:0], fits};
    end
  end

  assign quotient  = quo;
  assign remainder = acc;

endmodule

`default_nettype wire

>>> design/trial_division_factorizer_core.sv
// each trial divisor and each strip of a found factor takes one divider run; trial divisors
//   go up to floor(sqrt(value)), so a 32-bit prime near 2^32 is the worst case
// throughput: one item at a time, paced by the shared bit-serial divider (one quotient bit
//   per cycle); s_tready stays low until every result of the run is in the output register
// reset: rst is synchronous and active high, returns to idle and drops m_tvalid
`default_nettype none

module trial_division_factorizer_core #(
  parameter int VALUE_BITS = trdiv_pkg::VALUE_BITS_DEF
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  // input stream
  input  wire logic                             s_tvalid,
  output logic                                  s_tready,
  input  wire logic [trdiv_pkg::IN_DATA_W-1:0]  s_tdata,   // [31:0] value
  // result stream
  output logic                                  m_tvalid,
  input  wire logic                             m_tready,
  output logic [trdiv_pkg::OUT_DATA_W-1:0]      m_tdata,   // [31:0] prime, [36:32] exponent, pad
  output logic                                  m_tuser,   // [0] has_factor
  output logic                                  m_tlast    // last result of the run
);

  import trdiv_pkg::*;

  // datapath width: only the low VALUE_BITS bits of the input take part
  localparam int DW = (VALUE_BITS < IN_DATA_W) ? VALUE_BITS : IN_DATA_W;

  state_t state, state_next;

  // working registers
  logic [DW-1:0]    rem, rem_next;        // part of the value not yet factored
  logic [DW-1:0]    cand, cand_next;      // current trial divisor
  logic [EXP_W-1:0] mult, mult_next;      // strips of cand so far, nonzero while stripping

  // one factor is held back until we know whether it closes the run
  logic             pend_valid, pend_valid_next;
  logic [DW-1:0]    pend_prime, pend_prime_next;
  logic [EXP_W-1:0] pend_exp, pend_exp_next;

  // output register
  logic [DW-1:0]    out_prime;
  logic [EXP_W-1:0] out_exp;
  logic             out_has;
  logic             out_last;
  logic             out_free;

  // load strobe and payload for the output register
  logic             out_load;
  logic [DW-1:0]    load_prime;
  logic [EXP_W-1:0] load_exp;
  logic             load_has;
  logic             load_last;

  // shared divider
  logic             div_start;
  logic             div_done;
  logic [DW-1:0]    div_quo;
  logic [DW-1:0]    div_rem;

  // rem / cand gives both the remainder test and the loop bound:
  // cand*cand <= rem exactly when cand <= floor(rem / cand)
  trdiv_divider #(
    .DW (DW)
  ) u_divider (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start),
    .dividend  (rem),
    .divisor   (cand),
    .done      (div_done),
    .quotient  (div_quo),
    .remainder (div_rem)
  );

  assign out_free = !m_tvalid || m_tready;
  assign s_tready = (state == ST_IDLE);

  always_comb begin
    state_next      = state;
    rem_next        = rem;
    cand_next       = cand;
    mult_next       = mult;
    pend_valid_next = pend_valid;
    pend_prime_next = pend_prime;
    pend_exp_next   = pend_exp;
    out_load        = 1'b0;
    load_prime      = '0;
    load_exp        = '0;
    load_has        = 1'b0;
    load_last       = 1'b0;
    div_start       = 1'b0;

    unique case (state)
      ST_IDLE: begin
        if (s_tvalid) begin
          rem_next        = s_tdata[DW-1:0];
          cand_next       = DW'(2);
          mult_next       = '0;
          pend_valid_next = 1'b0;
          // one (and zero) have no factor at all
          state_next      = (s_tdata[DW-1:0] <= DW'(1)) ? ST_ONE : ST_TRY;
        end
      end

      ST_ONE: begin
        // single no-factor result
        if (out_free) begin
          out_load   = 1'b1;
          load_last  = 1'b1;
          state_next = ST_IDLE;
        end
      end

      ST_TRY: begin
        div_start  = 1'b1;
        state_next = ST_WAIT;
      end

      ST_WAIT: begin
        if (div_done) begin
          if (mult != '0) begin
            // stripping: keep dividing while cand still divides
            if (div_rem == '0) begin
              rem_next   = div_quo;
              mult_next  = mult + EXP_W'(1);
              state_next = ST_TRY;
            end else begin
              state_next = ST_NEXT;
            end
          end else if (cand > div_quo) begin
            // cand squared passed the remaining value
            state_next = ST_FINISH;
          end else if (div_rem == '0) begin
            rem_next   = div_quo;
            mult_next  = EXP_W'(1);
            state_next = ST_TRY;
          end else begin
            cand_next  = cand + DW'(1);
            state_next = ST_TRY;
          end
        end
      end

      ST_NEXT: begin
        // factor cand^mult is complete; the held one goes out first
        if (!pend_valid || out_free) begin
          if (pend_valid) begin
            out_load   = 1'b1;
            load_prime = pend_prime;
            load_exp   = pend_exp;
            load_has   = 1'b1;
          end
          pend_valid_next = 1'b1;
          pend_prime_next = cand;
          pend_exp_next   = mult;
          cand_next       = cand + DW'(1);
          mult_next       = '0;
          state_next      = ST_TRY;
        end
      end

      ST_FINISH: begin
        if (out_free) begin
          out_load = 1'b1;
          load_has = 1'b1;
          if (rem != DW'(1)) begin
            // leftover above one is a prime of exponent one
            if (pend_valid) begin
              load_prime      = pend_prime;
              load_exp        = pend_exp;
              pend_prime_next = rem;
              pend_exp_next   = EXP_W'(1);
              rem_next        = DW'(1);
            end else begin
              load_prime = rem;
              load_exp   = EXP_W'(1);
              load_last  = 1'b1;
              state_next = ST_IDLE;
            end
          end else begin
            load_prime = pend_prime;
            load_exp   = pend_exp;
            load_last  = 1'b1;
            state_next = ST_IDLE;
          end
        end
      end

      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      rem        <= '0;
      cand       <= DW'(2);
      mult       <= '0;
      pend_valid <= 1'b0;
    end else begin
      state      <= state_next;
      rem        <= rem_next;
      cand       <= cand_next;
      mult       <= mult_next;
      pend_valid <= pend_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    pend_prime <= pend_prime_next;
    pend_exp   <= pend_exp_next;
  end

  // output register: a result waits here while the sequencer moves on
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_prime <= load_prime;
      out_exp   <= load_exp;
      out_has   <= load_has;
      out_last  <= load_last;
    end
  end

  assign m_tdata = {{OUT_PAD_W{1'b0}}, out_exp, PRIME_W'(out_prime)};
  assign m_tuser = out_has;
  assign m_tlast = out_last;

endmodule

`default_nettype wire

>>> design/trdiv_checker.sv
`default_nettype none

module trdiv_checker (
  input wire logic                                clk,
  input wire logic                                rst,
  input wire logic                                s_tvalid,
  input wire logic                                s_tready,
  input wire logic                                m_tvalid,
  input wire logic                                m_tready,
  input wire logic [trdiv_pkg::OUT_DATA_W-1:0]    m_tdata,
  input wire logic                                m_tuser,
  input wire logic                                m_tlast
);

  import trdiv_pkg::*;

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
      && $stable(m_tlast))
    else $error("result changed while stalled");

  // one item at a time: no second accept right after the first
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("input taken again while busy");

  // no-factor result is a lone, all-zero, last item
  a_no_factor: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser |-> m_tlast && (m_tdata == '0))
    else $error("bad no-factor result");

  // a factor is at least two with a nonzero exponent
  a_factor: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser |-> (m_tdata[PRIME_W+EXP_W-1:PRIME_W] != '0)
      && (m_tdata[PRIME_W-1:0] > PRIME_W'(1)))
    else $error("bad factor result");

endmodule

bind trial_division_factorizer_core trdiv_checker u_trdiv_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser),
  .m_tlast  (m_tlast)
);

`default_nettype wire

>>> tb/sv/trial_division_factorizer_core_test.sv
`default_nettype none

module trial_division_factorizer_core_test;
  import trdiv_pkg::*;

  // generous watchdog bound on the whole run
  localparam int unsigned CYCLE_LIMIT  = 5_000_000;
  localparam int          MAX_IDLE     = 19;
  localparam int          HOLD_CYCLES  = 1500;
  localparam int          DRAIN_CYCLES = 200;
  localparam int          RANDOM_ITEMS = 84;

  // one expected result of a factorization run
  typedef struct packed {
    logic [PRIME_W-1:0] prime;
    logic [EXP_W-1:0]   exponent;
    logic               has_factor;
    logic               last;
  } factor_t;

  logic                  clk;
  logic                  rst;
  logic                  s_tvalid;
  logic                  s_tready;
  logic [IN_DATA_W-1:0]  s_tdata;
  logic                  m_tvalid;
  logic                  m_tready;
  logic [OUT_DATA_W-1:0] m_tdata;
  logic                  m_tuser;
  logic                  m_tlast;

  factor_t     expected_factors[$];
  int unsigned small_primes[11] = '{2, 3, 5, 7, 11, 13, 17, 19, 23, 29, 31};

  int unsigned cycle_count = 0;
  int          value_count = 0;
  int          factor_count = 0;
  int          error_count = 0;
  // per-side random idling, and a one-shot long stall request for the receiver
  bit          send_idling = 1'b1;
  bit          take_idling = 1'b1;
  bit          hold_request = 1'b0;

  trial_division_factorizer_core uut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  initial clk = 1'b0;
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // append one expected result at the tail of the queue
  function automatic void add_expected(input factor_t entry);
    expected_factors.insert(expected_factors.size(), entry);
  endfunction

  // expected run for one value: ascending primes with multiplicity, last flag on the final one
  function automatic void push_factorization(input logic [IN_DATA_W-1:0] value);
    longint unsigned rest;
    longint unsigned divisor;
    logic [EXP_W-1:0] count;
    factor_t          pending;
    bit               have_pending;
    rest = 64'(value);
    have_pending = 1'b0;
    if (rest <= 1) begin
      // input zero or one: a single result that carries no factor
      pending = '{prime: '0, exponent: '0, has_factor: 1'b0, last: 1'b1};
      add_expected(pending);
      return;
    end
    for (divisor = 2; divisor * divisor <= rest; divisor++) begin
      if (rest % divisor == 0) begin
        count = '0;
        while (rest % divisor == 0) begin
          count = count + 1'b1;
          rest = rest / divisor;
        end
        if (have_pending) add_expected(pending);
        pending = '{prime: divisor[PRIME_W-1:0], exponent: count, has_factor: 1'b1, last: 1'b0};
        have_pending = 1'b1;
      end
    end
    // whatever is left above one is itself prime
    if (rest != 1) begin
      if (have_pending) add_expected(pending);
      pending = '{prime: rest[PRIME_W-1:0], exponent: EXP_W'(1), has_factor: 1'b1,
                  last: 1'b0};
    end
    pending.last = 1'b1;
    add_expected(pending);
  endfunction

  // mix of plain small values, smooth products and shifted odd values so every bit toggles
  function automatic logic [IN_DATA_W-1:0] random_value();
    longint unsigned v;
    int unsigned     p;
    int              bits;
    int              shift;
    case ($urandom_range(0, 3))
      0, 1: return $urandom_range(1, 65535);
      2: begin
        v = 1;
        repeat ($urandom_range(1, 24)) begin
          p = small_primes[$urandom_range(0, 10)];
          if (v * p <= 64'hFFFF_FFFF) v = v * p;
        end
        return v[IN_DATA_W-1:0];
      end
      default: begin
        v = 64'($urandom_range(0, 2047) * 2 + 1);
        bits = $clog2(v + 1);
        shift = $urandom_range(0, 32 - bits);
        return v[IN_DATA_W-1:0] << shift;
      end
    endcase
  endfunction

  // called at a falling edge; returns at the falling edge after the item is taken
  task automatic send_value(input logic [IN_DATA_W-1:0] value);
    int gap;
    gap = send_idling ? $urandom_range(0, MAX_IDLE) : 0;
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= value;
    do @(posedge clk); while (!s_tready);
    push_factorization(value);
    value_count++;
    @(negedge clk);
  endtask

  // corner values: one, smallest primes, top exponent, all ones, most distinct primes,
  // large leftover prime, square of a prime
  task automatic test_directed_values();
    send_value(32'd1);
    send_value(32'd2);
    send_value(32'd3);
    send_value(32'd4);
    send_value(32'd30);
    send_value(32'h8000_0000);      // two to the 31st, exponent saturates the field
    send_value(32'hFFFF_FFFF);
    send_value(32'hAAAA_AAAA);
    send_value(32'h5555_5555);
    send_value(32'd223092870);      // nine distinct primes, the longest run
    send_value(32'd3486784401);     // three to the 20th
    send_value(32'd3869835264);     // two to the 16th times three to the 10th
    send_value(32'd65521);          // prime, trial runs to its root
    send_value(32'd1048573);        // prime near 2^20
    send_value(32'd2000006);        // two times a prime near one million
    send_value(32'd16752649);       // 4093 squared
    send_value(32'd1);
  endtask

  // receiver stalls for a long stretch while the sender keeps offering values
  task automatic test_backpressure();
    hold_request = 1'b1;
    send_value(32'd360360);
    send_value(32'd223092870);
    send_value(32'd97);
    send_value(32'd1);
    send_value(32'd1024);
    send_value(32'd12);
  endtask

  // random values in blocks, some blocks with no idling on one or both sides
  task automatic test_random_values();
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i % 14 == 0) begin
        send_idling = ($urandom_range(0, 2) != 0);
        take_idling = ($urandom_range(0, 2) != 0);
      end
      send_value(random_value());
    end
    send_idling = 1'b1;
    take_idling = 1'b1;
  endtask

  // result side: draw a stall per result, then compare against the oldest expectation
  initial begin
    int      stall;
    factor_t want;
    m_tready = 1'b0;
    while (rst !== 1'b0) @(negedge clk);
    forever begin
      stall = take_idling ? $urandom_range(0, MAX_IDLE) : 0;
      if (hold_request) begin
        stall = HOLD_CYCLES;
        hold_request = 1'b0;
      end
      if (stall > 0) begin
        m_tready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (!m_tvalid);
      factor_count++;
      if (expected_factors.size() == 0) begin
        $error("result with nothing expected: prime %0d exponent %0d", m_tdata[PRIME_W-1:0],
               m_tdata[PRIME_W +: EXP_W]);
        error_count++;
      end else begin
        want = expected_factors.pop_front();
        if (m_tdata[PRIME_W-1:0] !== want.prime) begin
          $error("prime: expected %0d, got %0d", want.prime, m_tdata[PRIME_W-1:0]);
          error_count++;
        end
        if (m_tdata[PRIME_W +: EXP_W] !== want.exponent) begin
          $error("exponent: expected %0d, got %0d", want.exponent, m_tdata[PRIME_W +: EXP_W]);
          error_count++;
        end
        if (m_tuser !== want.has_factor) begin
          $error("has_factor: expected %0b, got %0b", want.has_factor, m_tuser);
          error_count++;
        end
        if (m_tlast !== want.last) begin
          $error("last: expected %0b, got %0b", want.last, m_tlast);
          error_count++;
        end
      end
      @(negedge clk);
    end
  end

  // watchdog
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("trial_division_factorizer_core_test: done, errors");
    $finish;
  end

  initial begin
    rst      = 1'b1;
    s_tvalid = 1'b0;
    s_tdata  = '0;
    repeat (10) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    test_directed_values();
    test_backpressure();
    test_random_values();

    // drain: every expected result in, then a quiet tail to catch strays
    s_tvalid <= 1'b0;
    while (expected_factors.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (expected_factors.size() != 0) begin
      $error("%0d expected results never arrived", expected_factors.size());
      error_count++;
    end
    $display("factored %0d values (corner cases, long receiver stall, random mix),",
             value_count);
    $display("checked %0d prime/exponent results in %0d cycles", factor_count, cycle_count);
    if (error_count == 0) begin
      $display("trial_division_factorizer_core_test: done, clean");
    end else begin
      $display("trial_division_factorizer_core_test: done, errors");
    end
    $finish;
  end

endmodule

`default_nettype wire
